// ===== rtl/core/bsr_pkg.sv =====
// Shared types, widths and codes for the bisection square-root finder.
// No dependencies; every other file of the block imports this package.
package bsr_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int TARGET_W      = 48;
    localparam int TOL_W         = 31;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = (TARGET_W > TOL_W) ? TARGET_W : TOL_W;

    localparam int PROD_W  = 2 * VALUE_WIDTH;
    localparam int ALIGN_W = TARGET_W + FRACTION_BITS;
    localparam int CMP_W   = (PROD_W > ALIGN_W) ? PROD_W : ALIGN_W;
    localparam int SUM_W   = VALUE_WIDTH + 1;

    localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1638400);
    localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = CFG_IDX_W'(1);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_EXACT     = 2'd1,
        ST_INVALID   = 2'd2
    } t_status;

    // Sign of f(x) = x*x - c
    typedef struct packed {
        logic neg;
        logic zero;
    } t_fsign;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_A,
        S_CMP_A,
        S_SQ_B,
        S_CMP_B,
        S_CHECK,
        S_SQ_M,
        S_CMP_M,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/bsr_if.sv =====
// Valid/ready channel interfaces: input words, result words, register writes.
// Depends on bsr_pkg.
interface bsr_in_if;
    import bsr_pkg::*;
    logic   valid;
    logic   ready;
    t_value left_end;
    t_value right_end;
    modport source (output valid, left_end, right_end, input ready);
    modport sink   (input valid, left_end, right_end, output ready);
endinterface

interface bsr_out_if;
    import bsr_pkg::*;
    logic    valid;
    logic    ready;
    t_value  root;
    t_status status;
    modport source (output valid, root, status, input ready);
    modport sink   (input valid, root, status, output ready);
endinterface

interface bsr_cfg_if;
    import bsr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bsr_cfg_regs.sv =====
// Configuration registers: target square and stop tolerance.
// Depends on bsr_pkg and bsr_cfg_if.
module bsr_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bsr_cfg_if.sink                      i_cfg,
    output logic [bsr_pkg::TARGET_W-1:0] o_target,
    output logic [bsr_pkg::TOL_W-1:0]    o_tol
);
    import bsr_pkg::*;

    logic [TARGET_W-1:0] r_target, n_target;
    logic [TOL_W-1:0]    r_tol, n_tol;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_target = r_target;
        n_tol    = r_tol;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TARGET: n_target = i_cfg.data[TARGET_W-1:0];
                REG_TOL:    n_tol    = i_cfg.data[TOL_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
            r_tol    <= TOL_RESET;
        end else begin
            r_target <= n_target;
            r_tol    <= n_tol;
        end
    end

    // a zero tolerance acts as one LSB
    assign o_target = r_target;
    assign o_tol    = (r_tol == '0) ? TOL_W'(1) : r_tol;

endmodule

// ===== rtl/core/bsr_sign_unit.sv =====
// Shared square-and-compare unit: registered |x|*|x|, then sign of x*x - c.
// Depends on bsr_pkg.
module bsr_sign_unit (
    input  logic                         i_clk,
    input  bsr_pkg::t_value              i_operand,
    input  logic [bsr_pkg::TARGET_W-1:0] i_target,
    output bsr_pkg::t_fsign              o_sign
);
    import bsr_pkg::*;

    logic [VALUE_WIDTH-1:0] w_raw;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic [PROD_W-1:0]      r_prod;
    logic [CMP_W-1:0]       w_sq;
    logic [CMP_W-1:0]       w_c;

    assign w_raw = i_operand;
    assign w_mag = w_raw[VALUE_WIDTH-1] ? (~w_raw + VALUE_WIDTH'(1)) : w_raw;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_mag) * PROD_W'(w_mag);
    end

    assign w_sq = CMP_W'(r_prod);
    assign w_c  = CMP_W'(i_target) << FRACTION_BITS;

    assign o_sign.zero = (w_sq == w_c);
    assign o_sign.neg  = (w_sq < w_c);

endmodule

// ===== rtl/core/bsr_ctrl.sv =====
// Bisection sequencer: interval registers, width test, midpoint, result register.
// Depends on bsr_pkg, bsr_in_if and bsr_out_if; drives the shared sign unit.
module bsr_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bsr_in_if.sink                    i_in,
    bsr_out_if.source                 o_out,
    input  logic [bsr_pkg::TOL_W-1:0] i_tol,
    input  bsr_pkg::t_fsign           i_sign,
    output bsr_pkg::t_value           o_operand
);
    import bsr_pkg::*;

    t_state  r_state, n_state;
    t_value  r_a, n_a;
    t_value  r_b, n_b;
    t_value  r_mid, n_mid;
    t_fsign  r_sa, n_sa;
    t_value  r_res_root, n_res_root;
    t_status r_res_status, n_res_status;
    logic    r_out_valid, n_out_valid;
    t_value  r_out_root, n_out_root;
    t_status r_out_status, n_out_status;

    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_half;
    logic signed [SUM_W-1:0] w_diff;
    logic        [SUM_W-1:0] w_width;
    t_value                  w_mid;
    logic                    w_stop;

    // floor midpoint and absolute width
    assign w_sum   = SUM_W'(r_a) + SUM_W'(r_b);
    assign w_half  = w_sum >>> 1;
    assign w_mid   = w_half[VALUE_WIDTH-1:0];
    assign w_diff  = SUM_W'(r_b) - SUM_W'(r_a);
    assign w_width = w_diff[SUM_W-1] ? (~w_diff + SUM_W'(1)) : w_diff;
    assign w_stop  = (w_width <= SUM_W'(i_tol));

    always_comb begin
        case (r_state)
            S_SQ_A:  o_operand = r_a;
            S_SQ_B:  o_operand = r_b;
            default: o_operand = r_mid;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_a          = r_a;
        n_b          = r_b;
        n_mid        = r_mid;
        n_sa         = r_sa;
        n_res_root   = r_res_root;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_root   = r_out_root;
        n_out_status = r_out_status;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_a     = i_in.left_end;
                    n_b     = i_in.right_end;
                    n_state = S_SQ_A;
                end
            end
            S_SQ_A:  n_state = S_CMP_A;
            S_CMP_A: begin
                n_sa    = i_sign;
                n_state = S_SQ_B;
            end
            S_SQ_B:  n_state = S_CMP_B;
            S_CMP_B: begin
                if (!r_sa.zero && !i_sign.zero && (r_sa.neg == i_sign.neg)) begin
                    n_res_root   = '0;
                    n_res_status = ST_INVALID;
                    n_state      = S_DONE;
                end else if (r_sa.zero) begin
                    n_res_root   = r_a;
                    n_res_status = ST_EXACT;
                    n_state      = S_DONE;
                end else if (i_sign.zero) begin
                    n_res_root   = r_b;
                    n_res_status = ST_EXACT;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_stop) begin
                    n_res_root   = w_mid;
                    n_res_status = ST_CONVERGED;
                    n_state      = S_DONE;
                end else begin
                    n_mid   = w_mid;
                    n_state = S_SQ_M;
                end
            end
            S_SQ_M:  n_state = S_CMP_M;
            S_CMP_M: begin
                if (i_sign.zero) begin
                    n_res_root   = r_mid;
                    n_res_status = ST_EXACT;
                    n_state      = S_DONE;
                end else begin
                    // keep the half that still holds the sign change
                    if (i_sign.neg != r_sa.neg) begin
                        n_b = r_mid;
                    end else begin
                        n_a  = r_mid;
                        n_sa = i_sign;
                    end
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_root   = r_res_root;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a          <= n_a;
        r_b          <= n_b;
        r_mid        <= n_mid;
        r_sa         <= n_sa;
        r_res_root   <= n_res_root;
        r_res_status <= n_res_status;
        r_out_root   <= n_out_root;
        r_out_status <= n_out_status;
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.root   = r_out_root;
    assign o_out.status = r_out_status;

endmodule

// ===== rtl/core/bisection_square_root_finder.sv =====
// Bisection square-root finder, top level. One word in, one result word out.
// An exact end or an invalid interval is reported after the end checks; otherwise
// the search converges after k halvings (k <= 32 for a full-range interval) or
// stops when the k-th midpoint is an exact root; each halving passes through the
// width test (S_CHECK) and then the shared square unit (S_SQ_M, S_CMP_M).
// Throughput: one word at a time; the next word is taken once the result leaves
// the sequencer and it is back in idle, later while the result side stalls.
// Reset (synchronous, active low) idles the sequencer, drops any pending result
// and restores target 25.0 and tolerance one LSB.
module bisection_square_root_finder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsr_in_if.sink    i_in,
    bsr_out_if.source o_out,
    bsr_cfg_if.sink   i_cfg
);
    import bsr_pkg::*;

    logic [TARGET_W-1:0] w_target;
    logic [TOL_W-1:0]    w_tol;
    t_fsign              w_sign;
    t_value              w_operand;

    // Register file: target square c and stop tolerance.
    bsr_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_target (w_target),
        .o_tol    (w_tol)
    );

    // Shared unit: square the selected point, then sign of x*x - c.
    bsr_sign_unit u_sign (
        .i_clk     (i_clk),
        .i_operand (w_operand),
        .i_target  (w_target),
        .o_sign    (w_sign)
    );

    // Sequencer: end checks, halving loop, result register.
    bsr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .i_tol     (w_tol),
        .i_sign    (w_sign),
        .o_operand (w_operand)
    );

    // Invalid interval always reports a zero root.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_INVALID)) |-> (o_out.root == '0))
        else $error("invalid interval result carries a nonzero root");

    // Accepting a word starts a search; no second word in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken again right after an accept");

    // Effective tolerance is never zero, so the search always ends.
    a_tol_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (w_tol != '0))
        else $error("effective tolerance is zero");

endmodule
